>>> rtl/core/csgs_pkg.sv
`timescale 1ns / 1ps

package csgs_pkg;

   localparam int DEPTH  = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int PROD_W = 16 + CNT_W;

   localparam int VALUE_W     = 32;
   localparam int COUNT_W     = 7;
   localparam int STATUS_W    = 3;
   localparam int REQ_TYPE_W  = 2;
   localparam int RSP_W       = VALUE_W + COUNT_W + STATUS_W;
   localparam int RSP_TDATA_W = ((RSP_W + 7) / 8) * 8;

   localparam logic [31:0] POISON_WORD = 32'hFEEEDACE;
   localparam logic [15:0] CK_MOD      = 16'd65521;

   localparam logic [REQ_TYPE_W-1:0] REQ_PUSH  = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_POP   = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_PEEK  = 2'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_CHECK = 2'd3;

   localparam logic [STATUS_W-1:0] STS_OK     = 3'd0;
   localparam logic [STATUS_W-1:0] STS_FULL   = 3'd1;
   localparam logic [STATUS_W-1:0] STS_EMPTY  = 3'd2;
   localparam logic [STATUS_W-1:0] STS_POISON = 3'd3;
   localparam logic [STATUS_W-1:0] STS_SUM    = 3'd4;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] op;
      logic [VALUE_W-1:0]    value;
   } item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
      logic [VALUE_W-1:0]  data_out;
   } rsp_type;

   // Reduces a 32-bit word modulo 65521, using 2^16 = 15 (mod 65521).
   function automatic logic [15:0] ck_fold(input logic [31:0] x);
      logic [20:0] f1;
      logic [16:0] f2;
      f1 = {5'd0, x[15:0]} + ({5'd0, x[31:16]} << 4) - {5'd0, x[31:16]};
      f2 = {1'b0, f1[15:0]} + ({12'd0, f1[20:16]} << 4) - {12'd0, f1[20:16]};
      if (f2 >= {1'b0, CK_MOD}) begin
         ck_fold = 16'(f2 - {1'b0, CK_MOD});
      end else begin
         ck_fold = f2[15:0];
      end
   endfunction

endpackage

>>> rtl/core/csgs_front.sv
`timescale 1ns / 1ps

module csgs_front import csgs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [VALUE_W-1:0]    req_tdata,   // value
   input  logic [REQ_TYPE_W-1:0] req_tuser,   // req_type
   output logic                  out_valid,
   output item_type              out_item,
   input  logic                  out_ready
);

   logic     f_vld_ff, f_vld_in;
   item_type f_item_ff, f_item_in;
   item_type classified;

   // The pushed word matters only for a push; other requests carry zero.
   always_comb begin
      classified.op    = req_tuser;
      classified.value = (req_tuser == REQ_PUSH) ? req_tdata : '0;
   end

   assign req_tready = !f_vld_ff || out_ready;
   assign out_valid  = f_vld_ff;
   assign out_item   = f_item_ff;

   always_comb begin
      f_vld_in  = f_vld_ff;
      f_item_in = f_item_ff;
      if (req_tvalid && req_tready) begin
         f_vld_in  = 1'b1;
         f_item_in = classified;
      end else if (out_ready) begin
         f_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else begin
         f_vld_ff <= f_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      f_item_ff <= f_item_in;
   end

endmodule

>>> rtl/core/csgs_queue.sv
`timescale 1ns / 1ps

module csgs_queue import csgs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  item_type in_item,
   output logic     in_ready,
   output logic     out_valid,
   output item_type out_item,
   input  logic     out_ready
);

   item_type   q_mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   assign in_ready  = (fill_ff != 2'd2);
   assign out_valid = (fill_ff != 2'd0);
   assign out_item  = q_mem_ff[rd_ptr_ff];
   assign do_push   = in_valid && in_ready;
   assign do_pop    = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_mem_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

>>> rtl/core/csgs_back.sv
`timescale 1ns / 1ps

module csgs_back import csgs_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  item_type               q_item,
   output logic                   q_ready,
   output logic                   rsp_tvalid,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   rsp_tready
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_SUM   = 3'd2;
   localparam logic [2:0] S_WRD   = 3'd3;
   localparam logic [2:0] S_WMUL  = 3'd4;
   localparam logic [2:0] S_WACC  = 3'd5;
   localparam logic [2:0] S_WDONE = 3'd6;

   function automatic logic [15:0] mod_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, CK_MOD}) begin
         mod_add = 16'(s - {1'b0, CK_MOD});
      end else begin
         mod_add = s[15:0];
      end
   endfunction

   function automatic logic [15:0] mod_sub(input logic [15:0] a, input logic [15:0] b);
      if (a >= b) begin
         mod_sub = a - b;
      end else begin
         mod_sub = 16'({1'b0, a} + {1'b0, CK_MOD} - {1'b0, b});
      end
   endfunction

   logic [2:0]            state_ff, state_in;
   logic [REQ_TYPE_W-1:0] op_ff, op_in;
   logic [VALUE_W-1:0]    val_ff, val_in;
   logic [VALUE_W-1:0]    data_ff, data_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [15:0]           sum_ff, sum_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [15:0]           acc_ff, acc_in;
   logic                  bad_ff, bad_in;
   logic                  rsp_vld_ff, rsp_vld_in;
   rsp_type               rsp_ff, rsp_in;

   logic [VALUE_W-1:0]    mem [DEPTH];
   logic [DEPTH-1:0]      vld_ff;
   logic [VALUE_W-1:0]    rd_data_ff;
   logic                  rd_vld_ff;
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [VALUE_W-1:0]    wr_data;
   logic [ADDR_W-1:0]     rd_addr;

   logic                  out_free;
   logic                  emit;
   rsp_type               emit_rsp;
   logic [CNT_W-1:0]      cnt_inc, cnt_dec, idx_inc;
   logic [ADDR_W-1:0]     top_addr;
   logic [VALUE_W-1:0]    rd_word;
   logic [VALUE_W-1:0]    mul_src;
   logic [CNT_W-1:0]      mul_pos;
   logic [PROD_W-1:0]     prod_calc;
   logic [15:0]           term;
   logic                  in_used;
   logic                  is_full, is_empty;

   assign out_free  = !rsp_vld_ff || rsp_tready;
   assign cnt_inc   = cnt_ff + CNT_W'(1);
   assign cnt_dec   = cnt_ff - CNT_W'(1);
   assign idx_inc   = idx_ff + CNT_W'(1);
   assign top_addr  = cnt_dec[ADDR_W-1:0];
   assign is_full   = (cnt_ff == CNT_W'(DEPTH));
   assign is_empty  = (cnt_ff == '0);
   assign in_used   = (idx_ff < cnt_ff);
   // A slot never written since reset reads as poison through its cleared valid bit.
   assign rd_word   = rd_vld_ff ? rd_data_ff : POISON_WORD;
   assign term      = ck_fold(32'(prod_ff));

   // One multiplier serves the push, pop and walk terms.
   always_comb begin
      if (state_ff == S_EXEC && op_ff == REQ_PUSH) begin
         mul_src = val_ff;
         mul_pos = cnt_inc;
      end else if (state_ff == S_WMUL) begin
         mul_src = rd_word;
         mul_pos = idx_inc;
      end else begin
         mul_src = rd_word;
         mul_pos = cnt_ff;
      end
      prod_calc = PROD_W'(ck_fold(mul_src)) * PROD_W'(mul_pos);
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      val_in   = val_ff;
      data_in  = data_ff;
      prod_in  = prod_ff;
      cnt_in   = cnt_ff;
      sum_in   = sum_ff;
      idx_in   = idx_ff;
      acc_in   = acc_ff;
      bad_in   = bad_ff;
      q_ready  = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = top_addr;
      wr_data  = POISON_WORD;
      rd_addr  = top_addr;
      emit     = 1'b0;
      emit_rsp.data_out = '0;
      emit_rsp.count    = COUNT_W'(cnt_ff);
      emit_rsp.status   = STS_OK;

      case (state_ff)
         S_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               op_in  = q_item.op;
               val_in = q_item.value;
               if (q_item.op == REQ_CHECK) begin
                  idx_in   = '0;
                  acc_in   = '0;
                  bad_in   = 1'b0;
                  state_in = S_WRD;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_EXEC: begin
            case (op_ff)
               REQ_PUSH: begin
                  if (is_full) begin
                     emit_rsp.status = STS_FULL;
                     if (out_free) begin
                        emit     = 1'b1;
                        state_in = S_IDLE;
                     end
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = cnt_ff[ADDR_W-1:0];
                     wr_data  = val_ff;
                     data_in  = '0;
                     prod_in  = prod_calc;
                     cnt_in   = cnt_inc;
                     state_in = S_SUM;
                  end
               end
               REQ_POP: begin
                  if (is_empty) begin
                     emit_rsp.status = STS_EMPTY;
                     if (out_free) begin
                        emit     = 1'b1;
                        state_in = S_IDLE;
                     end
                  end else begin
                     wr_en    = 1'b1;
                     data_in  = rd_word;
                     prod_in  = prod_calc;
                     cnt_in   = cnt_dec;
                     state_in = S_SUM;
                  end
               end
               REQ_PEEK: begin
                  emit_rsp.status   = is_empty ? STS_EMPTY : STS_OK;
                  emit_rsp.data_out = is_empty ? '0 : rd_word;
                  if (out_free) begin
                     emit     = 1'b1;
                     state_in = S_IDLE;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_SUM: begin
            emit_rsp.data_out = data_ff;
            if (out_free) begin
               emit     = 1'b1;
               sum_in   = (op_ff == REQ_PUSH) ? mod_add(sum_ff, term) : mod_sub(sum_ff, term);
               state_in = S_IDLE;
            end
         end
         S_WRD: begin
            rd_addr  = idx_ff[ADDR_W-1:0];
            state_in = S_WMUL;
         end
         S_WMUL: begin
            if (in_used) begin
               prod_in = prod_calc;
            end else if (rd_word != POISON_WORD) begin
               bad_in = 1'b1;
            end
            state_in = S_WACC;
         end
         S_WACC: begin
            if (in_used) begin
               acc_in = mod_add(acc_ff, term);
            end
            // The next slot's read is issued here so it lands in S_WMUL.
            rd_addr = idx_inc[ADDR_W-1:0];
            idx_in  = idx_inc;
            if (idx_ff == CNT_W'(DEPTH - 1)) begin
               state_in = S_WDONE;
            end else begin
               state_in = S_WMUL;
            end
         end
         S_WDONE: begin
            // Damaged poison outranks a checksum mismatch.
            if (bad_ff) begin
               emit_rsp.status = STS_POISON;
            end else if (acc_ff != sum_ff) begin
               emit_rsp.status = STS_SUM;
            end
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      rsp_in     = rsp_ff;
      if (emit) begin
         rsp_vld_in = 1'b1;
         rsp_in     = emit_rsp;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - RSP_W){1'b0}}, rsp_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         cnt_ff     <= '0;
         sum_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         sum_ff     <= sum_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      val_ff  <= val_in;
      data_ff <= data_in;
      prod_ff <= prod_in;
      idx_ff  <= idx_in;
      acc_ff  <= acc_in;
      bad_ff  <= bad_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

endmodule

>>> rtl/core/checksummed_guarded_stack_core.sv
`timescale 1ns / 1ps

// A 64-word LIFO stack that guards its own integrity with a running checksum
// (sum of 1-based position times value, modulo 65521) and a poison word in
// every unused slot. Each request transaction (push, pop, peek or check)
// returns exactly one response transaction carrying the popped or peeked
// word, the entry count after the request and a status code. A front stage
// and a two-entry queue take requests while the back end works, so the input
// side stalls only once three requests are waiting. The back end owns a
// stack memory with one write port and one registered read port. Push and pop
// write it and update the checksum; peek and the full or empty refusals answer
// from the execute state; a check reads, weights and sums every slot in turn.
// There is no clearing pass after reset; per-slot valid bits make unwritten
// slots read as poison, so requests are taken from the first cycle after reset.
module checksummed_guarded_stack_core import csgs_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [VALUE_W-1:0]     req_tdata,   // value
   input  logic [REQ_TYPE_W-1:0]  req_tuser,   // req_type
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata    // data_out, count, status, zero fill
);

   logic     f_valid, f_ready;
   item_type f_item;
   logic     q_valid, q_ready;
   item_type q_item;
   rsp_type  rsp_view;

   csgs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .out_valid  (f_valid),
      .out_item   (f_item),
      .out_ready  (f_ready)
   );

   csgs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_item   (f_item),
      .in_ready  (f_ready),
      .out_valid (q_valid),
      .out_item  (q_item),
      .out_ready (q_ready)
   );

   csgs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_ready    (q_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tready (rsp_tready)
   );

   assign rsp_view = rsp_type'(rsp_tdata[RSP_W-1:0]);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_view.count <= COUNT_W'(DEPTH)))
      else $error("response count exceeds the stack depth");

   a_full_at_depth: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_view.status == STS_FULL) |->
         (rsp_view.count == COUNT_W'(DEPTH) && rsp_view.data_out == '0))
      else $error("full status reported below depth");

   a_empty_at_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_view.status == STS_EMPTY) |->
         (rsp_view.count == '0 && rsp_view.data_out == '0))
      else $error("empty status reported with entries present");

   // Nothing outside the block can touch the memory, so a check must pass.
   a_check_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_view.status != STS_POISON && rsp_view.status != STS_SUM))
      else $error("integrity check failed on internal state");

endmodule
